// ----- src/prw_pkg.sv -----
// ----------------------------------------------------------------------------
// prw_pkg: shared types and constants for the particle repulsion/wind step
// Field widths, stage records, pipeline depths and register indexes.
// ----------------------------------------------------------------------------
package prw_pkg;

    localparam int NUM_CENTERS = 5;
    localparam int FIELD_W     = 24;          // Q2.22 position / velocity
    localparam int DIFF_W      = 25;          // particle minus center
    localparam int SQ_W        = 50;          // square-root remainder / root
    localparam int ROOT_STEPS  = 25;          // one root bit per stage
    localparam int DIV_STEPS   = 24;          // one quotient bit per stage
    localparam int FORCE_W     = 37;          // one center's force term
    localparam int FORCE_LAT   = 56;          // force unit depth in stages
    localparam int WIND_W      = 20;
    localparam int DAMP_W      = 25;
    localparam int PROD_W      = 41;          // velocity times damping
    localparam int SUM_W       = 40;
    localparam int TRIG_W      = 17;
    localparam int AMP_W       = 17;

    localparam logic [TRIG_W-1:0] SIN_A = 17'd102944;
    localparam logic [TRIG_W-1:0] SIN_B = 17'd42334;
    localparam logic [TRIG_W-1:0] SIN_C = 17'd5223;
    localparam logic [TRIG_W-1:0] SIN_D = 17'd307;
    localparam logic [15:0]       QUARTER_TURN = 16'd16384;

    localparam int VEL_MAX = 8388607;
    localparam int VEL_MIN = -8388608;

    localparam logic [22:0] RADIUS_BASE_RST = 23'd629146;
    localparam logic [18:0] RADIUS_STEP_RST = 19'd41943;
    localparam logic [22:0] FORCE_GAIN_RST  = 23'd41943;

    typedef enum logic [2:0] {
        REG_CENTER_A    = 3'd0,
        REG_CENTER_B    = 3'd1,
        REG_CENTER_C    = 3'd2,
        REG_CENTER_D    = 3'd3,
        REG_CENTER_E    = 3'd4,
        REG_RADIUS_BASE = 3'd5,
        REG_RADIUS_STEP = 3'd6,
        REG_FORCE_GAIN  = 3'd7
    } cfg_reg_t;

    // square-root stage
    typedef struct packed {
        logic [SQ_W-1:0]          rem;
        logic [SQ_W-1:0]          root;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [23:0]              radius;
        logic                     nz;
    } sq_stage_t;

    // restoring divider stage, both axes share the divisor
    typedef struct packed {
        logic [DIFF_W-1:0] rem_x;
        logic [DIFF_W-1:0] rem_y;
        logic [23:0]       nq_x;
        logic [23:0]       nq_y;
        logic [DIFF_W-1:0] len;
        logic              neg_x;
        logic              neg_y;
        logic              hit;
    } div_stage_t;

    typedef struct packed {
        logic [TRIG_W-1:0] z;
        logic [TRIG_W-1:0] z2;
        logic [TRIG_W-1:0] t;
        logic              neg;
    } wind_stage_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [PROD_W-1:0]  prod_x;
        logic signed [PROD_W-1:0]  prod_y;
    } front_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [DAMP_W-1:0]  damp_x;
        logic signed [DAMP_W-1:0]  damp_y;
        logic signed [WIND_W-1:0]  wind_x;
        logic signed [WIND_W-1:0]  wind_y;
    } side_t;

endpackage

// ----- src/prw_force.sv -----
// ----------------------------------------------------------------------------
// prw_force: repulsion from one center
// Distance by pipelined square root, scaled direction by pipelined divider.
// ----------------------------------------------------------------------------
module prw_force #(
    parameter int FRAC_BITS = 22
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [prw_pkg::FIELD_W-1:0]   pos_x,
    input  logic signed [prw_pkg::FIELD_W-1:0]   pos_y,
    input  logic signed [prw_pkg::FIELD_W-1:0]   cen_x,
    input  logic signed [prw_pkg::FIELD_W-1:0]   cen_y,
    input  logic [2:0]                           layer,
    input  logic [22:0]                          radius_base,
    input  logic [18:0]                          radius_step,
    input  logic [22:0]                          gain,
    output logic signed [prw_pkg::FORCE_W-1:0]   force_x,
    output logic signed [prw_pkg::FORCE_W-1:0]   force_y
);

    localparam int DW = prw_pkg::DIFF_W;
    localparam int GW = 49;
    localparam logic [GW-1:0] HALF = GW'(1) << (FRAC_BITS - 1);

    function automatic logic signed [prw_pkg::FORCE_W-1:0] round_shift
        (input logic signed [GW-1:0] v);
        logic [GW-1:0] mag;
        logic [GW-1:0] sh;
        mag = v[GW-1] ? GW'(-v) : GW'(v);
        sh  = (mag + HALF) >> FRAC_BITS;
        round_shift = v[GW-1] ? -$signed(prw_pkg::FORCE_W'(sh))
                              : $signed(prw_pkg::FORCE_W'(sh));
    endfunction

    logic signed [DW-1:0]   dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic [2:0]             layer1_reg, layer2_reg;
    logic [47:0]            sqx2_reg, sqy2_reg;
    logic signed [2*DW-1:0] sqx_full, sqy_full;
    logic [48:0]            d2;
    logic [23:0]            rad;

    prw_pkg::sq_stage_t  sq_reg  [0:prw_pkg::ROOT_STEPS];
    prw_pkg::div_stage_t div_reg [0:prw_pkg::DIV_STEPS];

    logic [23:0]          magx_reg, magy_reg, diff_reg;
    logic [DW-1:0]        len_reg;
    logic                 negx_reg, negy_reg, hit_reg;
    logic [DW-1:0]        len_c;
    logic signed [DW-1:0] absx_c, absy_c;
    logic [47:0]          numx, numy;

    logic signed [DW-1:0] qx, qy;
    logic signed [GW-1:0] prodx_reg, prody_reg;
    logic signed [prw_pkg::FORCE_W-1:0] force_x_reg, force_y_reg;

    // difference and squares
    assign sqx_full = dx1_reg * dx1_reg;
    assign sqy_full = dy1_reg * dy1_reg;
    assign d2  = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
    assign rad = {1'b0, radius_base} + 24'(radius_step) * 24'(layer2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg    <= $signed({pos_x[23], pos_x}) - $signed({cen_x[23], cen_x});
            dy1_reg    <= $signed({pos_y[23], pos_y}) - $signed({cen_y[23], cen_y});
            layer1_reg <= layer;
            dx2_reg    <= dx1_reg;
            dy2_reg    <= dy1_reg;
            sqx2_reg   <= sqx_full[47:0];
            sqy2_reg   <= sqy_full[47:0];
            layer2_reg <= layer1_reg;
            sq_reg[0].rem    <= prw_pkg::SQ_W'(d2);
            sq_reg[0].root   <= '0;
            sq_reg[0].dx     <= dx2_reg;
            sq_reg[0].dy     <= dy2_reg;
            sq_reg[0].radius <= rad;
            sq_reg[0].nz     <= (d2 != '0);
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < prw_pkg::ROOT_STEPS; k++)
    begin : g_root
        localparam logic [prw_pkg::SQ_W-1:0] BIT =
            prw_pkg::SQ_W'(1) << (2 * (prw_pkg::ROOT_STEPS - 1 - k));
        logic [prw_pkg::SQ_W-1:0] trial;
        prw_pkg::sq_stage_t       nxt;
        assign trial = sq_reg[k].root + BIT;

        always_comb
        begin
            nxt = sq_reg[k];
            if (sq_reg[k].rem >= trial)
            begin
                nxt.rem  = sq_reg[k].rem - trial;
                nxt.root = (sq_reg[k].root >> 1) + BIT;
            end
            else
            begin
                nxt.root = sq_reg[k].root >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k+1] <= nxt;
            end
        end
    end

    // range check and magnitudes
    assign len_c  = sq_reg[prw_pkg::ROOT_STEPS].root[DW-1:0];
    assign absx_c = sq_reg[prw_pkg::ROOT_STEPS].dx[DW-1] ?
                    -sq_reg[prw_pkg::ROOT_STEPS].dx : sq_reg[prw_pkg::ROOT_STEPS].dx;
    assign absy_c = sq_reg[prw_pkg::ROOT_STEPS].dy[DW-1] ?
                    -sq_reg[prw_pkg::ROOT_STEPS].dy : sq_reg[prw_pkg::ROOT_STEPS].dy;
    assign numx   = magx_reg * diff_reg;
    assign numy   = magy_reg * diff_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            magx_reg <= absx_c[23:0];
            magy_reg <= absy_c[23:0];
            negx_reg <= sq_reg[prw_pkg::ROOT_STEPS].dx[DW-1];
            negy_reg <= sq_reg[prw_pkg::ROOT_STEPS].dy[DW-1];
            diff_reg <= sq_reg[prw_pkg::ROOT_STEPS].radius - len_c[23:0];
            len_reg  <= len_c;
            hit_reg  <= sq_reg[prw_pkg::ROOT_STEPS].nz &&
                        (len_c < {1'b0, sq_reg[prw_pkg::ROOT_STEPS].radius});
            div_reg[0].rem_x <= {1'b0, numx[47:24]};
            div_reg[0].rem_y <= {1'b0, numy[47:24]};
            div_reg[0].nq_x  <= numx[23:0];
            div_reg[0].nq_y  <= numy[23:0];
            div_reg[0].len   <= len_reg;
            div_reg[0].neg_x <= negx_reg;
            div_reg[0].neg_y <= negy_reg;
            div_reg[0].hit   <= hit_reg;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < prw_pkg::DIV_STEPS; j++)
    begin : g_div
        logic [DW:0]         tx, ty;
        logic                gex, gey;
        prw_pkg::div_stage_t nxt;
        assign tx  = {div_reg[j].rem_x, div_reg[j].nq_x[23]};
        assign ty  = {div_reg[j].rem_y, div_reg[j].nq_y[23]};
        assign gex = tx >= {1'b0, div_reg[j].len};
        assign gey = ty >= {1'b0, div_reg[j].len};

        always_comb
        begin
            nxt       = div_reg[j];
            nxt.rem_x = gex ? DW'(tx - {1'b0, div_reg[j].len}) : tx[DW-1:0];
            nxt.rem_y = gey ? DW'(ty - {1'b0, div_reg[j].len}) : ty[DW-1:0];
            nxt.nq_x  = {div_reg[j].nq_x[22:0], gex};
            nxt.nq_y  = {div_reg[j].nq_y[22:0], gey};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[j+1] <= nxt;
            end
        end
    end

    // quotient truncates toward zero, then gain and rounding
    assign qx = div_reg[prw_pkg::DIV_STEPS].neg_x ?
                -$signed({1'b0, div_reg[prw_pkg::DIV_STEPS].nq_x}) :
                $signed({1'b0, div_reg[prw_pkg::DIV_STEPS].nq_x});
    assign qy = div_reg[prw_pkg::DIV_STEPS].neg_y ?
                -$signed({1'b0, div_reg[prw_pkg::DIV_STEPS].nq_y}) :
                $signed({1'b0, div_reg[prw_pkg::DIV_STEPS].nq_y});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // both arms signed so the quotient keeps its sign
            prodx_reg   <= div_reg[prw_pkg::DIV_STEPS].hit ?
                           qx * $signed({1'b0, gain}) : $signed(GW'(0));
            prody_reg   <= div_reg[prw_pkg::DIV_STEPS].hit ?
                           qy * $signed({1'b0, gain}) : $signed(GW'(0));
            force_x_reg <= round_shift(prodx_reg);
            force_y_reg <= round_shift(prody_reg);
        end
    end

    assign force_x = force_x_reg;
    assign force_y = force_y_reg;

endmodule

// ----- src/particle_repulsion_wind_step.sv -----
// ----------------------------------------------------------------------------
// particle_repulsion_wind_step: one motion update of one 2-D particle
// Repulsion from five centers, wind, damping, saturation and wrap-around.
// ----------------------------------------------------------------------------
// Takes one particle request per clock while the output side does not stall,
// and returns one updated particle for each, in order. The depth is set by the
// per-center distance square root (25 stages, one root bit each) and the
// divider that normalizes the direction (24 stages, one quotient bit each);
// five force units run side by side, while wind (quarter-wave sine
// polynomial) and damping are computed in a short side path and held until
// the forces arrive. The whole pipeline advances together: it moves whenever
// the output register is empty or taken, so s_tready drops only while a
// finished result waits. Center, radius and gain registers are read directly
// by every stage, so they must be written only while no request is in flight.
// ----------------------------------------------------------------------------
module particle_repulsion_wind_step #(
    parameter int FRAC_BITS = 22
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[23:0], pos_y[47:24], vel_x[71:48], vel_y[95:72],
    // damping[111:96], wind_phase[127:112]
    input  logic [127:0] s_tdata,
    // layer[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x[23:0], new_pos_y[47:24], new_vel_x[71:48], new_vel_y[95:72]
    output logic [95:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [47:0]  cfg_wdata
);

    localparam int FW        = prw_pkg::FIELD_W;
    localparam int OUT_STAGE = prw_pkg::FORCE_LAT + 3;
    localparam int SIDE_IN   = 6;
    localparam logic signed [31:0] POS_ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic [prw_pkg::AMP_W-1:0] WIND_AMP =
        prw_pkg::AMP_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

    function automatic logic signed [prw_pkg::DAMP_W-1:0] damp_round
        (input logic signed [prw_pkg::PROD_W-1:0] v);
        logic [prw_pkg::PROD_W-1:0] mag;
        logic [prw_pkg::PROD_W-1:0] sh;
        mag = v[prw_pkg::PROD_W-1] ? prw_pkg::PROD_W'(-v) : prw_pkg::PROD_W'(v);
        sh  = (mag + prw_pkg::PROD_W'(32768)) >> 16;
        damp_round = v[prw_pkg::PROD_W-1] ? -$signed(prw_pkg::DAMP_W'(sh))
                                          : $signed(prw_pkg::DAMP_W'(sh));
    endfunction

    function automatic logic [prw_pkg::TRIG_W-1:0] sin_coef(input int k);
        case (k)
            2:       sin_coef = prw_pkg::SIN_C;
            3:       sin_coef = prw_pkg::SIN_B;
            default: sin_coef = prw_pkg::SIN_A;
        endcase
    endfunction

    // ---------------- configuration registers ----------------
    logic [47:0] center_reg [prw_pkg::NUM_CENTERS];
    logic [22:0] radius_base_reg;
    logic [18:0] radius_step_reg;
    logic [22:0] force_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < prw_pkg::NUM_CENTERS; c++)
            begin
                center_reg[c] <= '0;
            end
            radius_base_reg <= prw_pkg::RADIUS_BASE_RST;
            radius_step_reg <= prw_pkg::RADIUS_STEP_RST;
            force_gain_reg  <= prw_pkg::FORCE_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (prw_pkg::cfg_reg_t'(cfg_addr))
                prw_pkg::REG_CENTER_A:    center_reg[0]   <= cfg_wdata;
                prw_pkg::REG_CENTER_B:    center_reg[1]   <= cfg_wdata;
                prw_pkg::REG_CENTER_C:    center_reg[2]   <= cfg_wdata;
                prw_pkg::REG_CENTER_D:    center_reg[3]   <= cfg_wdata;
                prw_pkg::REG_CENTER_E:    center_reg[4]   <= cfg_wdata;
                prw_pkg::REG_RADIUS_BASE: radius_base_reg <= cfg_wdata[22:0];
                prw_pkg::REG_RADIUS_STEP: radius_step_reg <= cfg_wdata[18:0];
                prw_pkg::REG_FORCE_GAIN:  force_gain_reg  <= cfg_wdata[22:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // One enable for every stage; valid bits shift alongside the data.
    logic [OUT_STAGE:0] vld_reg;
    logic               adv;

    assign adv      = !vld_reg[OUT_STAGE] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[OUT_STAGE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[OUT_STAGE-1:0], s_tvalid};
        end
    end

    // ---------------- stage 0: request register ----------------
    logic signed [FW-1:0] pos_x0_reg, pos_y0_reg, vel_x0_reg, vel_y0_reg;
    logic [15:0]          damp0_reg, phase0_reg;
    logic [2:0]           layer0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_x0_reg <= s_tdata[23:0];
            pos_y0_reg <= s_tdata[47:24];
            vel_x0_reg <= s_tdata[71:48];
            vel_y0_reg <= s_tdata[95:72];
            damp0_reg  <= s_tdata[111:96];
            phase0_reg <= s_tdata[127:112];
            layer0_reg <= s_tuser;
        end
    end

    // ---------------- repulsion: one unit per center ----------------
    logic signed [prw_pkg::FORCE_W-1:0] fx [prw_pkg::NUM_CENTERS];
    logic signed [prw_pkg::FORCE_W-1:0] fy [prw_pkg::NUM_CENTERS];

    for (genvar c = 0; c < prw_pkg::NUM_CENTERS; c++)
    begin : g_center
        prw_force #(
            .FRAC_BITS (FRAC_BITS)
        ) u_force (
            .clk         (clk),
            .en          (adv),
            .pos_x       (pos_x0_reg),
            .pos_y       (pos_y0_reg),
            .cen_x       (center_reg[c][47:24]),
            .cen_y       (center_reg[c][23:0]),
            .layer       (layer0_reg),
            .radius_base (radius_base_reg),
            .radius_step (radius_step_reg),
            .gain        (force_gain_reg),
            .force_x     (fx[c]),
            .force_y     (fy[c])
        );
    end

    // ---------------- stages 1..5: damping product, wind sine ----------------
    // Axis 0 is x (cosine: phase plus a quarter turn), axis 1 is y (sine).
    prw_pkg::front_t      fr_reg [1:5];
    prw_pkg::wind_stage_t wd_reg [2][1:5];

    logic [15:0]                 wph  [2];
    logic [14:0]                 warg [2];
    logic [prw_pkg::TRIG_W-1:0]  wz   [2];
    logic [2*prw_pkg::TRIG_W-1:0] wzz [2];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            wph[a]  = (a == 0) ? phase0_reg + prw_pkg::QUARTER_TURN : phase0_reg;
            // odd quadrants mirror the angle
            warg[a] = wph[a][14] ? 15'(prw_pkg::QUARTER_TURN - {2'b00, wph[a][13:0]})
                                 : {1'b0, wph[a][13:0]};
            wz[a]   = {warg[a], 2'b00};
            wzz[a]  = wz[a] * wz[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fr_reg[1].pos_x  <= pos_x0_reg;
            fr_reg[1].pos_y  <= pos_y0_reg;
            fr_reg[1].prod_x <= vel_x0_reg * $signed({1'b0, damp0_reg});
            fr_reg[1].prod_y <= vel_y0_reg * $signed({1'b0, damp0_reg});
            for (int k = 2; k <= 5; k++)
            begin
                fr_reg[k] <= fr_reg[k-1];
            end
        end
    end

    for (genvar a = 0; a < 2; a++)
    begin : g_wind_in
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                wd_reg[a][1].z   <= wz[a];
                wd_reg[a][1].z2  <= prw_pkg::TRIG_W'(wzz[a] >> 16);
                wd_reg[a][1].t   <= prw_pkg::SIN_D;
                wd_reg[a][1].neg <= wph[a][15];
            end
        end
    end

    // nested polynomial: t = coef - z2*t, one product per stage
    for (genvar k = 2; k <= 4; k++)
    begin : g_poly
        for (genvar a = 0; a < 2; a++)
        begin : g_axis
            logic [2*prw_pkg::TRIG_W-1:0] p;
            prw_pkg::wind_stage_t         nxt;
            assign p = wd_reg[a][k-1].z2 * wd_reg[a][k-1].t;

            always_comb
            begin
                nxt   = wd_reg[a][k-1];
                nxt.t = sin_coef(k) - prw_pkg::TRIG_W'(p >> 16);
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    wd_reg[a][k] <= nxt;
                end
            end
        end
    end

    for (genvar a = 0; a < 2; a++)
    begin : g_sine
        logic [2*prw_pkg::TRIG_W-1:0] p;
        prw_pkg::wind_stage_t         nxt;
        assign p = wd_reg[a][4].z * wd_reg[a][4].t;

        always_comb
        begin
            nxt   = wd_reg[a][4];
            nxt.t = prw_pkg::TRIG_W'(p >> 16);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                wd_reg[a][5] <= nxt;
            end
        end
    end

    // ---------------- stage 6 onward: side data waits for the forces ----------
    prw_pkg::side_t side_reg [SIDE_IN:prw_pkg::FORCE_LAT];

    logic [2*prw_pkg::TRIG_W-1:0]      wprod [2];
    logic [2*prw_pkg::TRIG_W:0]        wrnd  [2];
    logic signed [prw_pkg::WIND_W-1:0] wval  [2];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            wprod[a] = wd_reg[a][5].t * WIND_AMP;
            wrnd[a]  = ({1'b0, wprod[a]} + 35'd32768) >> 16;
            wval[a]  = wd_reg[a][5].neg ? -$signed(prw_pkg::WIND_W'(wrnd[a]))
                                        : $signed(prw_pkg::WIND_W'(wrnd[a]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[SIDE_IN].pos_x  <= fr_reg[5].pos_x;
            side_reg[SIDE_IN].pos_y  <= fr_reg[5].pos_y;
            side_reg[SIDE_IN].damp_x <= damp_round(fr_reg[5].prod_x);
            side_reg[SIDE_IN].damp_y <= damp_round(fr_reg[5].prod_y);
            side_reg[SIDE_IN].wind_x <= wval[0];
            side_reg[SIDE_IN].wind_y <= wval[1];
            for (int k = SIDE_IN + 1; k <= prw_pkg::FORCE_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- tail: sum, saturate, move and wrap ----------------
    localparam int SW = prw_pkg::SUM_W;

    logic signed [SW-1:0] suma_reg [2];
    logic signed [SW-1:0] sumb_reg [2];
    logic signed [FW-1:0] pos57_reg [2];
    logic signed [FW-1:0] pos58_reg [2];
    logic signed [FW-1:0] vel58_reg [2];
    logic signed [FW-1:0] out_pos_reg [2];
    logic signed [FW-1:0] out_vel_reg [2];

    logic signed [SW-1:0] vsum [2];
    logic signed [FW-1:0] vsat [2];
    logic signed [31:0]   pnew [2];
    logic signed [FW-1:0] pwrap [2];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            vsum[a] = suma_reg[a] + sumb_reg[a];
            if (vsum[a] > SW'(prw_pkg::VEL_MAX))
            begin
                vsat[a] = FW'(prw_pkg::VEL_MAX);
            end
            else if (vsum[a] < SW'(prw_pkg::VEL_MIN))
            begin
                vsat[a] = FW'(prw_pkg::VEL_MIN);
            end
            else
            begin
                vsat[a] = vsum[a][FW-1:0];
            end

            pnew[a] = 32'(pos58_reg[a]) + 32'(vel58_reg[a]);
            if (pnew[a] > POS_ONE)
            begin
                pwrap[a] = FW'(-POS_ONE);
            end
            else if (pnew[a] < -POS_ONE)
            begin
                pwrap[a] = FW'(POS_ONE);
            end
            else
            begin
                pwrap[a] = pnew[a][FW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            suma_reg[0] <= SW'(fx[0]) + SW'(fx[1]) + SW'(fx[2])
                           + SW'(side_reg[prw_pkg::FORCE_LAT].wind_x);
            sumb_reg[0] <= SW'(fx[3]) + SW'(fx[4])
                           + SW'(side_reg[prw_pkg::FORCE_LAT].damp_x);
            suma_reg[1] <= SW'(fy[0]) + SW'(fy[1]) + SW'(fy[2])
                           + SW'(side_reg[prw_pkg::FORCE_LAT].wind_y);
            sumb_reg[1] <= SW'(fy[3]) + SW'(fy[4])
                           + SW'(side_reg[prw_pkg::FORCE_LAT].damp_y);
            pos57_reg[0] <= side_reg[prw_pkg::FORCE_LAT].pos_x;
            pos57_reg[1] <= side_reg[prw_pkg::FORCE_LAT].pos_y;
            for (int a = 0; a < 2; a++)
            begin
                vel58_reg[a]   <= vsat[a];
                pos58_reg[a]   <= pos57_reg[a];
                out_vel_reg[a] <= vel58_reg[a];
                out_pos_reg[a] <= pwrap[a];
            end
        end
    end

    assign m_tdata = {out_vel_reg[1], out_vel_reg[0], out_pos_reg[1], out_pos_reg[0]};

endmodule

// ----- src/prw_checker.sv -----
// ----------------------------------------------------------------------------
// prw_checker: port-level checks for the particle update block
// Flow control and output range, bound to the top level.
// ----------------------------------------------------------------------------
module prw_checker #(
    parameter int FRAC_BITS = 22
) (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata
);

    localparam logic signed [31:0] POS_ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] out_x, out_y;
    assign out_x = 32'($signed(m_tdata[23:0]));
    assign out_y = 32'($signed(m_tdata[47:24]));

    // input is never blocked while the output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // wrapped position stays within plus or minus one
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_x >= -POS_ONE) && (out_x <= POS_ONE) &&
                     (out_y >= -POS_ONE) && (out_y <= POS_ONE))
        else $error("output position outside wrap range");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

endmodule

bind particle_repulsion_wind_step prw_checker #(.FRAC_BITS(FRAC_BITS)) u_prw_checker (.*);

// ----- tb/tb_particle_repulsion_wind_step.sv -----
// ----------------------------------------------------------------------------
// tb_particle_repulsion_wind_step: self-checking bench for the particle step
// Drives particle requests with random gaps, stalls the output at random, and
// compares every returned particle with an in-bench fixed-point model of the
// repulsion, wind, damping, saturation and wrap rules.
// ----------------------------------------------------------------------------
class particle_scoreboard;
    logic [95:0] pending_q[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    // note the expected output of one accepted request
    function void note_request(logic [95:0] exp_word);
        pending_q.push_back(exp_word);
    endfunction

    function void check_result(logic [95:0] got);
        logic [95:0] exp_word;
        int          k;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_word = pending_q.pop_front();
        for (k = 0; k < 4; k++)
        begin
            if (exp_word[k*24 +: 24] !== got[k*24 +: 24])
            begin
                $display("%0t: field %0d expected %h actual %h",
                         $time, k, exp_word[k*24 +: 24], got[k*24 +: 24]);
                errors++;
            end
        end
    endfunction
endclass

module tb_particle_repulsion_wind_step;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = 22;
    localparam int LATENCY  = 59;
    localparam int N_RANDOM = 400;
    localparam longint ONE  = 64'sd1 << FRAC;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [47:0]  cfg_wdata;

    particle_repulsion_wind_step #(.FRAC_BITS(FRAC)) uut (.*);

    // shadow copy of the block's registers
    logic [47:0] centers[prw_pkg::NUM_CENTERS];
    logic [22:0] rad_base;
    logic [18:0] rad_step;
    logic [22:0] gain;

    particle_scoreboard sb;
    bit  quiet_mode;   // no idling in the final part
    longint cycles;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // timeout watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic longint sx24(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 << (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // quarter-wave sine, Q16
    function automatic longint unsigned qsine(longint unsigned u);
        longint unsigned z, z2, t;
        z  = u << 2;
        z2 = (z * z) >> 16;
        t  = 5223 - ((z2 * 307) >> 16);
        t  = 42334 - ((z2 * t) >> 16);
        t  = 102944 - ((z2 * t) >> 16);
        return (z * t) >> 16;
    endfunction

    function automatic longint wind_comp(logic [15:0] ph, longint amp);
        logic [1:0] quad;
        longint unsigned u, s;
        longint w;
        quad = ph[15:14];
        u = ph[13:0];
        s = quad[0] ? qsine(16384 - u) : qsine(u);
        w = longint'((s * longint'(amp) + 32768) >> 16);
        return quad[1] ? -w : w;
    endfunction

    function automatic longint clamp_vel(longint v);
        if (v > prw_pkg::VEL_MAX) return prw_pkg::VEL_MAX;
        if (v < prw_pkg::VEL_MIN) return prw_pkg::VEL_MIN;
        return v;
    endfunction

    function automatic longint wrap_coord(longint p);
        if (p > ONE) return -ONE;
        if (p < -ONE) return ONE;
        return p;
    endfunction

    function automatic logic [95:0] predict_particle(logic [127:0] d, logic [2:0] lyr);
        longint px, py, vx, vy, damp, radius, amp, fx, fy, dx, dy, len;
        longint unsigned d2;
        logic [95:0] r;
        px = sx24(d[23:0]);
        py = sx24(d[47:24]);
        vx = sx24(d[71:48]);
        vy = sx24(d[95:72]);
        damp = d[111:96];
        radius = longint'(rad_base) + longint'(lyr) * longint'(rad_step);
        amp = ((64'sd1 << FRAC) + 5000) / 10000;
        fx = 0;
        fy = 0;
        for (int i = 0; i < prw_pkg::NUM_CENTERS; i++)
        begin
            dx = px - sx24(centers[i][47:24]);
            dy = py - sx24(centers[i][23:0]);
            d2 = longint'(dx * dx) + longint'(dy * dy);
            if (d2 == 0) continue;   // coincident center gives nothing
            len = int_sqrt(d2);
            if (len >= radius) continue;
            fx += rnd_shift(((dx * (radius - len)) / len) * longint'(gain), FRAC);
            fy += rnd_shift(((dy * (radius - len)) / len) * longint'(gain), FRAC);
        end
        fx += wind_comp(d[127:112] + prw_pkg::QUARTER_TURN, amp);
        fy += wind_comp(d[127:112], amp);
        vx = clamp_vel(rnd_shift(vx * damp, 16) + fx);
        vy = clamp_vel(rnd_shift(vy * damp, 16) + fy);
        px = wrap_coord(px + vx);
        py = wrap_coord(py + vy);
        r = {vy[23:0], vx[23:0], py[23:0], px[23:0]};
        return r;
    endfunction

    task automatic write_reg(prw_pkg::cfg_reg_t idx, logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            prw_pkg::REG_RADIUS_BASE: rad_base = val[22:0];
            prw_pkg::REG_RADIUS_STEP: rad_step = val[18:0];
            prw_pkg::REG_FORCE_GAIN:  gain = val[22:0];
            default:                  centers[idx] = val;
        endcase
    endtask

    // wait until every expected particle is back, then let the pipe drain
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic send_particle(logic [127:0] d, logic [2:0] lyr);
        if (!quiet_mode && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= lyr;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(predict_particle(d, lyr));
    endtask

    function automatic logic [23:0] rnd_pos();
        case ($urandom_range(5))
            0: return 24'(-ONE);
            1: return 24'(ONE);
            2: return 24'($urandom());        // anything, may be out of range
            default: return 24'($signed($urandom_range(0, 2 * ONE)) - ONE);
        endcase
    endfunction

    function automatic logic [23:0] rnd_vel();
        case ($urandom_range(4))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom());
            default: return 24'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    function automatic logic [127:0] rnd_particle();
        logic [127:0] d;
        d[23:0]    = rnd_pos();
        d[47:24]   = rnd_pos();
        d[71:48]   = rnd_vel();
        d[95:72]   = rnd_vel();
        d[111:96]  = 16'($urandom());
        d[127:112] = 16'($urandom());
        return d;
    endfunction

    // random center, mostly within plus or minus one, so repulsion fires often
    function automatic logic [47:0] rnd_center();
        logic [23:0] cx, cy;
        cx = 24'($signed($urandom_range(0, 2 * ONE)) - ONE);
        cy = ($urandom_range(7) == 0) ? 24'($urandom()) :
             24'($signed($urandom_range(0, 2 * ONE)) - ONE);
        return {cx, cy};
    endfunction

    // output side: random stalls, check every accepted result
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet_mode && $urandom_range(3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    initial
    begin
        logic [127:0] d;
        sb = new();
        quiet_mode = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 0;
        cfg_addr = prw_pkg::REG_CENTER_A;
        cfg_wdata = '0;
        for (int i = 0; i < prw_pkg::NUM_CENTERS; i++) centers[i] = '0;
        rad_base = prw_pkg::RADIUS_BASE_RST;
        rad_step = prw_pkg::RADIUS_STEP_RST;
        gain = prw_pkg::FORCE_GAIN_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset registers, all centers at the origin
        send_particle({16'd0, 16'hFFFF, 24'h000000, 24'h000000, 24'd0, 24'd0}, 3'd0);
        send_particle({16'd0, 16'd65535, 24'h7FFFFF, 24'h7FFFFF, 24'd4000, 24'd0}, 3'd4);
        send_particle({16'h4000, 16'hFFFF, 24'h800000, 24'h800000,
                       24'(-ONE), 24'(ONE)}, 3'd7);
        send_particle({16'h8000, 16'h8000, 24'h000010, 24'hFFFFF0,
                       24'(ONE), 24'(-ONE)}, 3'd2);
        send_particle({16'hC000, 16'hFFFF, 24'h100000, 24'h100000,
                       24'(ONE - 5), 24'(ONE - 5)}, 3'd1);
        send_particle({16'h3FFF, 16'h0000, 24'hF00000, 24'hF00000,
                       24'(-ONE + 5), 24'(-ONE + 5)}, 3'd5);
        send_particle({16'd0, 16'd0, 24'd0, 24'd0, 24'h7FFFFF, 24'h800000}, 3'd6);
        send_particle({16'h1234, 16'h8000, 24'd100, 24'd100, 24'd300, 24'd200}, 3'd3);
        drain_pipe();

        // extremes of every register
        write_reg(prw_pkg::REG_CENTER_A, {24'd100, 24'd100});
        write_reg(prw_pkg::REG_CENTER_B, {24'h7FFFFF, 24'h800000});
        write_reg(prw_pkg::REG_CENTER_C, 48'hFFFFFFFFFFFF);
        write_reg(prw_pkg::REG_CENTER_D, {24'(ONE), 24'(-ONE)});
        write_reg(prw_pkg::REG_CENTER_E, {24'h200000, 24'h000000});
        write_reg(prw_pkg::REG_RADIUS_BASE, 48'd4194304);
        write_reg(prw_pkg::REG_RADIUS_STEP, 48'd419430);
        write_reg(prw_pkg::REG_FORCE_GAIN, 48'd4194304);
        send_particle({16'h2000, 16'hC000, 24'd0, 24'd0, 24'd100, 24'd100}, 3'd4);
        send_particle({16'h6000, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'd0, 24'd0}, 3'd7);
        send_particle({16'hA000, 16'h0001, 24'h800000, 24'h800000,
                       24'h200000, 24'd50}, 3'd0);
        send_particle({16'hE000, 16'h8000, 24'd5, 24'd5, 24'd100, 24'd101}, 3'd2);
        drain_pipe();
        write_reg(prw_pkg::REG_RADIUS_BASE, 48'd0);
        write_reg(prw_pkg::REG_RADIUS_STEP, 48'd0);
        write_reg(prw_pkg::REG_FORCE_GAIN, 48'd0);
        send_particle({16'h5555, 16'hAAAA, 24'd0, 24'd0, 24'd100, 24'd100}, 3'd4);
        send_particle({16'hAAAA, 16'h5555, 24'd77, 24'd77, 24'd101, 24'd99}, 3'd7);
        drain_pipe();

        // random phases, new settings each time
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int i = 0; i < prw_pkg::NUM_CENTERS; i++)
                write_reg(prw_pkg::cfg_reg_t'(i), rnd_center());
            write_reg(prw_pkg::REG_RADIUS_BASE, 48'($urandom_range(0, 4194304)));
            write_reg(prw_pkg::REG_RADIUS_STEP, 48'($urandom_range(0, 419430)));
            write_reg(prw_pkg::REG_FORCE_GAIN, 48'($urandom_range(0, 4194304)));
            if (ph == 7) quiet_mode = 1;
            for (int n = 0; n < N_RANDOM / 8; n++)
            begin
                d = rnd_particle();
                send_particle(d, 3'($urandom()));
            end
            drain_pipe();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
